// ----- design/lpst_pkg.sv -----
package lpst_pkg;

    // shape codes, in register order
    localparam logic [3:0] SH_CIRCLE = 4'd0;
    localparam logic [3:0] SH_RECT3  = 4'd1;
    localparam logic [3:0] SH_RECT4  = 4'd2;
    localparam logic [3:0] SH_SQUARE = 4'd3;
    localparam logic [3:0] SH_TRI    = 4'd4;
    localparam logic [3:0] SH_SHARP  = 4'd5;
    localparam logic [3:0] SH_FLAT   = 4'd6;
    localparam logic [3:0] SH_HEX    = 4'd7;
    localparam logic [3:0] SH_TRAP   = 4'd8;
    localparam logic [3:0] SH_OCT    = 4'd9;
    localparam logic [3:0] SH_DEC    = 4'd10;
    localparam logic [3:0] SH_DODEC  = 4'd11;

    // register index, taken from paddr[2]
    localparam logic REG_SHAPE = 1'b0;
    localparam logic REG_SCALE = 1'b1;

    localparam int APB_ADDR_BITS = 3;
    localparam int NUM_LANES     = 12;

    localparam logic [NUM_LANES-1:0] MASK_OCT   = 12'h0FF;
    localparam logic [NUM_LANES-1:0] MASK_DEC   = 12'h3FF;
    localparam logic [NUM_LANES-1:0] MASK_DODEC = 12'hFFF;

    // round(v12 * 1e-12 * 2^f)
    function automatic longint fx(input longint unsigned v12, input int f);
        longint unsigned t;
        t = (v12 << (f - 12)) + 64'd122070312;
        return longint'(t / 64'd244140625);
    endfunction

    function automatic longint cos_first(input int d, input int f);
        case (d)
            0:       return fx(64'd1000000000000, f);
            18:      return fx(64'd951056516295, f);
            30:      return fx(64'd866025403784, f);
            36:      return fx(64'd809016994375, f);
            45:      return fx(64'd707106781187, f);
            54:      return fx(64'd587785252292, f);
            60:      return fx(64'd500000000000, f);
            72:      return fx(64'd309016994375, f);
            default: return 64'sd0;
        endcase
    endfunction

    function automatic longint trig_cos(input int deg, input int f);
        int q;
        int r;
        q = (deg / 90) & 3;
        r = deg % 90;
        case (q)
            0:       return cos_first(r, f);
            1:       return -cos_first(90 - r, f);
            2:       return -cos_first(r, f);
            default: return cos_first(90 - r, f);
        endcase
    endfunction

    function automatic longint trig_sin(input int deg, input int f);
        int q;
        int r;
        q = (deg / 90) & 3;
        r = deg % 90;
        case (q)
            0:       return cos_first(90 - r, f);
            1:       return cos_first(r, f);
            2:       return -cos_first(90 - r, f);
            default: return -cos_first(r, f);
        endcase
    endfunction

endpackage

// ----- design/lattice_point_in_shape_test.sv -----
// Lattice point in shape test.
// Input stream s_*: one lattice point per item, px in s_tdata[COORD_BITS-1:0] and
// py in the next COORD_BITS bits. Result stream m_*: m_tdata[0] is 1 when the
// point is inside or on the shape selected by the shape_select register, scaled
// so that its area is pi*scale^2. Registers sit on the APB port: shape_select at
// address 0, scale at address 4; write them only while no item is in flight.
// Throughput: one item per cycle while the output is not stalled. The five
// register stages are: capture, constant and coordinate products, sums and
// compares, split slope products of the polygon lanes, and the output
// register. Octagon, decagon and dodecagon use eight, ten and all twelve of
// the twelve rotation lanes, working in parallel.
// Reset clears all stage valid bits and loads shape_select 0 (circle) and
// scale 16. When m_tready is low, items close up behind the output register
// and s_tready drops only once every stage holds an item; nothing is dropped.
module lattice_point_in_shape_test
    import lpst_pkg::*;
#(
    parameter int COORD_BITS = 13,
    parameter int FRAC_BITS  = 20
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: px, py
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]  s_tdata,
    // m_tdata: inside_res
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [APB_ADDR_BITS-1:0]           paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int F   = FRAC_BITS;
    localparam int CB  = COORD_BITS;
    localparam int W   = 2*F + CB + 8;
    localparam int WK  = 2*F + 5;
    localparam int WT  = F + 3;
    localparam int WWB = F + 10;
    localparam int WL  = WWB / 2;
    localparam int WH  = WWB - WL;
    localparam int DB  = CB + 12;

    typedef logic signed [W-1:0] wide_t;

    localparam longint R3    = fx(64'd1732050807569, F);
    localparam longint K_R3  = fx(64'd1023326707946, F);
    localparam longint K_R4  = fx(64'd886226925453, F);
    localparam longint K_SQ  = fx(64'd1772453850906, F);
    localparam longint K_TRI = fx(64'd2693547374178, F);
    localparam longint K_SHP = fx(64'd1834979252719, F);
    localparam longint T_SHP = fx(64'd3732050807569, F);
    localparam longint K_FLT = fx(64'd3869885957254, F);
    localparam longint T_FLT = fx(64'd839099631177, F);
    localparam longint K_HEX = fx(64'd2199272221582, F);
    localparam longint K_TRP = fx(64'd1253314137316, F);
    localparam longint KR8   = fx(64'd1053907365255, F);
    localparam longint KA8   = fx(64'd973683443900, F);
    localparam longint KS8   = fx(64'd403312888000, F);
    localparam longint TP8   = fx(64'd414213562373, F);
    localparam longint KR10  = fx(64'd1033904895278, F);
    localparam longint KA10  = fx(64'd983301987910, F);
    localparam longint KS10  = fx(64'd319494183210, F);
    localparam longint TP10  = fx(64'd324919696233, F);
    localparam longint KR12  = fx(64'd1023326707946, F);
    localparam longint KA12  = fx(64'd988457695900, F);
    localparam longint KS12  = fx(64'd264856441360, F);
    localparam longint TP12  = fx(64'd267949192431, F);

    function automatic wide_t ks_mul(input logic signed [WK-1:0] k, input logic [9:0] sv);
        logic signed [WK+10:0] p;
        p = k * $signed({1'b0, sv});
        return W'(p);
    endfunction

    function automatic wide_t xc_mul(input logic signed [CB-1:0] a,
                                     input logic signed [WT-1:0] c);
        logic signed [CB+WT-1:0] p;
        p = a * c;
        return W'(p);
    endfunction

    // configuration registers
    logic [3:0] shape_reg;
    logic [9:0] scale_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SCALE) ? {22'd0, scale_reg} : {28'd0, shape_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_reg <= SH_CIRCLE;
            scale_reg <= 10'd16;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_SHAPE: shape_reg <= pwdata[3:0];
                REG_SCALE: scale_reg <= pwdata[9:0];
                default:   shape_reg <= shape_reg;
            endcase
        end
    end

    // pipeline control: a stage loads when it is empty or its successor loads
    logic [4:0] vld_reg;
    logic [4:0] en;

    assign en[4] = !vld_reg[4] || m_tready;
    assign en[3] = !vld_reg[3] || en[4];
    assign en[2] = !vld_reg[2] || en[3];
    assign en[1] = !vld_reg[1] || en[2];
    assign en[0] = !vld_reg[0] || en[1];
    assign s_tready = en[0];
    assign m_tvalid = vld_reg[4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) vld_reg[0] <= s_tvalid;
            if (en[1]) vld_reg[1] <= vld_reg[0];
            if (en[2]) vld_reg[2] <= vld_reg[1];
            if (en[3]) vld_reg[3] <= vld_reg[2];
            if (en[4]) vld_reg[4] <= vld_reg[3];
        end
    end

    // stage 0: capture
    logic signed [CB-1:0] x0_reg, y0_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            x0_reg <= $signed(s_tdata[CB-1:0]);
            y0_reg <= $signed(s_tdata[2*CB-1:CB]);
        end
    end

    // stage 1: products
    logic signed [WK-1:0] klx_sel, klt_sel, ka_sel, ks_sel;
    logic signed [WT-1:0] tx_sel;
    logic [F-1:0]         tp_sel;

    always_comb begin
        klx_sel = '0;
        klt_sel = '0;
        tx_sel  = '0;
        ka_sel  = WK'(KA12);
        ks_sel  = WK'(KS12);
        tp_sel  = F'(TP12);
        unique case (shape_reg)
            SH_RECT3: begin
                klx_sel = WK'(3 * K_R3);
                klt_sel = WK'(K_R3);
            end
            SH_RECT4: begin
                klx_sel = WK'(4 * K_R4);
                klt_sel = WK'(K_R4);
            end
            SH_SQUARE: begin
                klx_sel = WK'(K_SQ);
                klt_sel = WK'(K_SQ);
            end
            SH_TRI: begin
                klx_sel = WK'(K_TRI);
                klt_sel = WK'(K_TRI * R3);
                tx_sel  = WT'(R3);
            end
            SH_SHARP: begin
                klx_sel = WK'(K_SHP);
                klt_sel = WK'(K_SHP * T_SHP);
                tx_sel  = WT'(T_SHP);
            end
            SH_FLAT: begin
                klx_sel = WK'(K_FLT);
                klt_sel = WK'(K_FLT * T_FLT);
                tx_sel  = WT'(T_FLT);
            end
            SH_HEX: begin
                klx_sel = WK'(K_HEX);
                klt_sel = WK'(K_HEX * R3);
                tx_sel  = WT'(R3);
            end
            SH_TRAP: begin
                klx_sel = WK'(K_TRP);
            end
            SH_OCT: begin
                ka_sel = WK'(KA8);
                ks_sel = WK'(KS8);
                tp_sel = F'(TP8);
            end
            SH_DEC: begin
                ka_sel = WK'(KA10);
                ks_sel = WK'(KS10);
                tp_sel = F'(TP10);
            end
            default: begin
                klx_sel = '0;
            end
        endcase
    end

    logic signed [DB-1:0]   cdx_next, cdy_next;
    logic signed [CB-1:0]   x1_reg, y1_reg;
    wide_t                  plx1_reg, plt1_reg, pxt1_reg, pa1_reg, ps1_reg;
    logic signed [2*DB-1:0] sqx1_reg, sqy1_reg;
    logic [19:0]            ss1_reg;

    assign cdx_next = DB'(x0_reg) - $signed({{(DB-10){1'b0}}, scale_reg});
    assign cdy_next = DB'(y0_reg) - $signed({{(DB-10){1'b0}}, scale_reg});

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            x1_reg   <= x0_reg;
            y1_reg   <= y0_reg;
            plx1_reg <= ks_mul(klx_sel, scale_reg);
            plt1_reg <= ks_mul(klt_sel, scale_reg);
            pxt1_reg <= xc_mul(x0_reg, tx_sel);
            pa1_reg  <= ks_mul(ka_sel, scale_reg);
            ps1_reg  <= ks_mul(ks_sel, scale_reg);
            sqx1_reg <= cdx_next * cdx_next;
            sqy1_reg <= cdy_next * cdy_next;
            ss1_reg  <= scale_reg * scale_reg;
        end
    end

    // stage 2: compares for the non-polygon shapes
    wide_t                xw, yw, lx, lt, pxt, gq, hw, x4;
    logic signed [2*DB:0] csum;
    logic                 np2_next;
    logic                 np2_reg;
    wide_t                ps2_reg;

    always_comb begin
        xw   = W'(x1_reg) <<< F;
        yw   = W'(y1_reg) <<< F;
        lx   = plx1_reg;
        lt   = plt1_reg;
        pxt  = pxt1_reg;
        gq   = lt >>> F;
        x4   = xw <<< 2;
        hw   = '0;
        csum = (2*DB+1)'(sqx1_reg) + (2*DB+1)'(sqy1_reg);
        np2_next = 1'b0;
        unique case (shape_reg)
            SH_CIRCLE: begin
                np2_next = csum <= $signed((2*DB+1)'(ss1_reg));
            end
            SH_RECT3, SH_RECT4, SH_SQUARE: begin
                np2_next = !x1_reg[CB-1] && !y1_reg[CB-1] && xw <= lx && yw <= lt;
            end
            SH_TRI, SH_SHARP, SH_FLAT: begin
                np2_next = !y1_reg[CB-1] &&
                           ((!x1_reg[CB-1] && (xw <<< 1) < lx && yw <= pxt) ||
                            ((xw <<< 1) >= lx && xw <= lx && yw <= gq - pxt));
            end
            SH_HEX: begin
                if (!x1_reg[CB-1] && x4 < lx) begin
                    hw = pxt <<< 2;
                    np2_next = (yw <<< 2) >= gq - hw && (yw <<< 2) <= gq + hw;
                end else if (x4 >= lx && x4 < 3 * lx) begin
                    np2_next = !y1_reg[CB-1] && (yw <<< 1) <= gq;
                end else if (x4 >= 3 * lx && xw <= lx) begin
                    hw = (gq - pxt) <<< 2;
                    np2_next = (yw <<< 2) >= gq - hw && (yw <<< 2) <= gq + hw;
                end
            end
            SH_TRAP: begin
                np2_next = !y1_reg[CB-1] &&
                           ((!x1_reg[CB-1] && xw < lx && y1_reg <= x1_reg) ||
                            (xw >= lx && xw < (lx <<< 1) && yw <= lx) ||
                            (xw >= (lx <<< 1) && xw <= 3 * lx && yw <= 3 * lx - xw));
            end
            default: begin
                np2_next = 1'b0;
            end
        endcase
    end

    logic   np3_reg;
    wide_t  ps3_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            np2_reg <= np2_next;
            ps2_reg <= ps1_reg;
        end
        if (en[3]) begin
            np3_reg <= np2_reg;
            ps3_reg <= ps2_reg;
        end
    end

    // rotation lanes for the regular polygons
    logic [NUM_LANES-1:0] lane_hit;

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        localparam longint C8  = trig_cos(i * 45, F);
        localparam longint S8  = trig_sin(i * 45, F);
        localparam longint C10 = trig_cos(i * 36, F);
        localparam longint S10 = trig_sin(i * 36, F);
        localparam longint C12 = trig_cos(i * 30, F);
        localparam longint S12 = trig_sin(i * 30, F);

        logic signed [WT-1:0] c_sel, s_sel;
        logic signed [WK-1:0] kac_sel, krs_sel, krc_sel, kas_sel;

        always_comb begin
            unique case (shape_reg)
                SH_OCT: begin
                    c_sel   = WT'(C8);
                    s_sel   = WT'(S8);
                    kac_sel = WK'(-(KA8 * C8));
                    krs_sel = WK'(-(KR8 * S8));
                    krc_sel = WK'(-(KR8 * C8));
                    kas_sel = WK'(-(KA8 * S8));
                end
                SH_DEC: begin
                    c_sel   = WT'(C10);
                    s_sel   = WT'(S10);
                    kac_sel = WK'(-(KA10 * C10));
                    krs_sel = WK'(-(KR10 * S10));
                    krc_sel = WK'(-(KR10 * C10));
                    kas_sel = WK'(-(KA10 * S10));
                end
                default: begin
                    c_sel   = WT'(C12);
                    s_sel   = WT'(S12);
                    kac_sel = WK'(-(KA12 * C12));
                    krs_sel = WK'(-(KR12 * S12));
                    krc_sel = WK'(-(KR12 * C12));
                    kas_sel = WK'(-(KA12 * S12));
                end
            endcase
        end

        // stage 1: coordinate and offset products
        wide_t pxc1_reg, pys1_reg, pyc1_reg, pxs1_reg;
        wide_t qa1_reg, qb1_reg, qc1_reg, qd1_reg;

        always_ff @(posedge aclk) begin
            if (en[1]) begin
                pxc1_reg <= xc_mul(x0_reg, c_sel);
                pys1_reg <= xc_mul(y0_reg, s_sel);
                pyc1_reg <= xc_mul(y0_reg, c_sel);
                pxs1_reg <= xc_mul(x0_reg, s_sel);
                qa1_reg  <= ks_mul(kac_sel, scale_reg);
                qb1_reg  <= ks_mul(krs_sel, scale_reg);
                qc1_reg  <= ks_mul(krc_sel, scale_reg);
                qd1_reg  <= ks_mul(kas_sel, scale_reg);
            end
        end

        // stage 2: rotated coordinates, w along the apothem
        wide_t          w_next, v_next;
        logic [WWB-1:0] w2_reg;
        wide_t          v2_reg;
        logic           rng2_reg;

        assign w_next = pxc1_reg + pys1_reg + (qa1_reg >>> F) + (qb1_reg >>> F) + pa1_reg;
        assign v_next = pyc1_reg + (qc1_reg >>> F) - pxs1_reg - (qd1_reg >>> F);

        always_ff @(posedge aclk) begin
            if (en[2]) begin
                w2_reg   <= w_next[WWB-1:0];
                v2_reg   <= v_next;
                rng2_reg <= !w_next[W-1] && w_next <= pa1_reg;
            end
        end

        // stage 3: slope product, split in two halves
        logic [WH+F-1:0] ph3_reg;
        logic [WL+F-1:0] pl3_reg;
        wide_t           v3_reg;
        logic            rng3_reg;

        always_ff @(posedge aclk) begin
            if (en[3]) begin
                ph3_reg  <= w2_reg[WWB-1:WL] * tp_sel;
                pl3_reg  <= w2_reg[WL-1:0] * tp_sel;
                v3_reg   <= v2_reg;
                rng3_reg <= rng2_reg;
            end
        end

        // stage 4: wedge test
        logic [WWB+F:0] tsum;
        wide_t          tq;

        assign tsum = (WWB+F+1)'({ph3_reg, {WL{1'b0}}}) + (WWB+F+1)'(pl3_reg);
        assign tq   = W'(tsum >> F);
        assign lane_hit[i] = rng3_reg && v3_reg >= tq - ps3_reg && v3_reg <= ps3_reg - tq;
    end

    // stage 4: output register
    logic res4_next;
    logic res4_reg;

    always_comb begin
        unique case (shape_reg)
            SH_OCT:   res4_next = |(lane_hit & MASK_OCT);
            SH_DEC:   res4_next = |(lane_hit & MASK_DEC);
            SH_DODEC: res4_next = |(lane_hit & MASK_DODEC);
            default:  res4_next = np3_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            res4_reg <= res4_next;
        end
    end

    assign m_tdata = {7'd0, res4_reg};

endmodule

// ----- design/lpst_chk.sv -----
module lpst_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic        pready,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:1] == 7'd0)
        else $error("result padding not zero");

    a_rd_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        prdata[31:10] == 22'd0)
        else $error("register readback has stray upper bits");

    // a scale write reads back on the next cycle
    a_scale_rb: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready && paddr[2]) ##1 (paddr[2] && !pwrite)
        |-> prdata[9:0] == $past(pwdata[9:0]))
        else $error("scale readback mismatch");

endmodule

bind lattice_point_in_shape_test lpst_chk u_lpst_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);
